[rtl/s2i_pkg.sv]
`timescale 1ns / 1ps

package s2i_pkg;

    localparam int CHAR_BITS       = 8;
    localparam int BASE_BITS       = 6;
    localparam int VALUE_OUT_BITS  = 32;
    localparam int OFFSET_OUT_BITS = 12;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [0:0] REG_NUMBER_BASE = 1'b0;
    localparam logic [0:0] REG_SIGNED_MODE = 1'b1;

    localparam logic [BASE_BITS-1:0] BASE_RESET   = 6'd10;
    localparam logic                 SIGNED_RESET = 1'b1;

    localparam logic [BASE_BITS-1:0] RADIX_AUTO = 6'd0;
    localparam logic [BASE_BITS-1:0] RADIX_BIN  = 6'd2;
    localparam logic [BASE_BITS-1:0] RADIX_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] RADIX_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] RADIX_HEX  = 6'd16;

    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_BITS-1:0] UPPER_BIAS = 8'd55;  // 'A' - 10
    localparam logic [CHAR_BITS-1:0] LOWER_BIAS = 8'd87;  // 'a' - 10

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [BASE_BITS-1:0] number_base;
        logic                 signed_mode;
    } t_cfg;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic                 starts_string;
    } t_item;

    typedef struct packed {
        logic                 ok;
        logic [BASE_BITS-1:0] val;
    } t_digit;

    function automatic t_digit digit_of(input logic [CHAR_BITS-1:0] c);
        t_digit               d;
        logic [CHAR_BITS-1:0] diff;
        d.ok = 1'b1;
        diff = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff = c - CH_ZERO;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            diff = c - UPPER_BIAS;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            diff = c - LOWER_BIAS;
        end else begin
            d.ok = 1'b0;
        end
        d.val = diff[BASE_BITS-1:0];
        return d;
    endfunction

endpackage

[rtl/s2i_if.sv]
`timescale 1ns / 1ps

interface s2i_in_if;
    logic                          valid;
    logic                          ready;
    logic [s2i_pkg::CHAR_BITS-1:0] char_code;
    logic                          starts_string;

    modport source (output valid, output char_code, output starts_string, input ready);
    modport sink   (input valid, input char_code, input starts_string, output ready);
endinterface

interface s2i_out_if;
    logic                                valid;
    logic                                ready;
    logic [s2i_pkg::VALUE_OUT_BITS-1:0]  value_bits;
    logic                                overflowed;
    logic                                digits_found;
    logic [s2i_pkg::OFFSET_OUT_BITS-1:0] end_offset;

    modport source (output valid, output value_bits, output overflowed,
                    output digits_found, output end_offset, input ready);
    modport sink   (input valid, input value_bits, input overflowed,
                    input digits_found, input end_offset, output ready);
endinterface

[rtl/s2i_cfg_regs.sv]
`timescale 1ns / 1ps

module s2i_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [s2i_pkg::CFG_ADDR_BITS-1:0] i_paddr,
    input  logic [s2i_pkg::CFG_DATA_BITS-1:0] i_pwdata,
    output logic [s2i_pkg::CFG_DATA_BITS-1:0] o_prdata,
    output logic                              o_pready,
    output s2i_pkg::t_cfg                     o_cfg
);
    import s2i_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [0:0] reg_idx;

    assign reg_idx  = i_paddr[2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_NUMBER_BASE: n_cfg.number_base = i_pwdata[BASE_BITS-1:0];
                REG_SIGNED_MODE: n_cfg.signed_mode = i_pwdata[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NUMBER_BASE: o_prdata = CFG_DATA_BITS'(r_cfg.number_base);
            REG_SIGNED_MODE: o_prdata = CFG_DATA_BITS'(r_cfg.signed_mode);
            default:         o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.number_base <= BASE_RESET;
            r_cfg.signed_mode <= SIGNED_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/s2i_in_stage.sv]
`timescale 1ns / 1ps

module s2i_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    s2i_in_if.sink         i_in,
    input  logic           i_take,
    output logic           o_valid,
    output s2i_pkg::t_item o_item
);
    import s2i_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.char_code     <= i_in.char_code;
            r_item.starts_string <= i_in.starts_string;
        end
    end

endmodule

[rtl/s2i_core.sv]
`timescale 1ns / 1ps

module s2i_core #(
    parameter int WORD_BITS   = 32,
    parameter int OFFSET_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  s2i_pkg::t_cfg  i_cfg,
    input  logic           i_item_valid,
    input  s2i_pkg::t_item i_item,
    output logic           o_take,
    s2i_out_if.source      o_out
);
    import s2i_pkg::*;

    localparam int PROD_BITS = WORD_BITS + BASE_BITS;

    // parse state
    t_phase                 r_phase,  n_phase;
    logic [WORD_BITS-1:0]   r_acc,    n_acc;
    logic                   r_neg,    n_neg;
    logic [BASE_BITS-1:0]   r_radix,  n_radix;
    logic                   r_any,    n_any;
    logic                   r_err,    n_err;
    logic [OFFSET_BITS-1:0] r_pos,    n_pos;

    // result register
    logic                       r_out_valid;
    logic [VALUE_OUT_BITS-1:0]  r_value,  n_value;
    logic                       r_ovf,    n_ovf;
    logic                       r_found,  n_found;
    logic [OFFSET_OUT_BITS-1:0] r_offset, n_offset;

    // state seen by this character (after an optional restart)
    t_phase                 e_phase;
    logic [WORD_BITS-1:0]   e_acc;
    logic                   e_neg;
    logic [BASE_BITS-1:0]   e_radix;
    logic                   e_any;
    logic                   e_err;
    logic [OFFSET_BITS-1:0] e_pos;
    logic [OFFSET_BITS-1:0] pos_inc;

    logic [CHAR_BITS-1:0]   c;
    t_digit                 dig;
    logic                   is_ws, is_sign, lead_zero, pfx_x, pfx_b;
    logic [BASE_BITS-1:0]   first_radix, zero_radix;

    logic                   s_step;
    logic [BASE_BITS-1:0]   s_radix;
    logic                   s_any;
    logic                   d_ok;
    logic                   emit;

    logic [WORD_BITS-1:0]   smax, smin, limit, word_val;
    logic [PROD_BITS-1:0]   prod;
    logic                   ovf;
    logic [63:0]            val_wide;
    logic [31:0]            pos_wide;

    assign o_take = i_item_valid && (!r_out_valid || o_out.ready);
    assign c      = i_item.char_code;

    always_comb begin
        if (i_item.starts_string) begin
            e_phase = PH_SPACE;
            e_acc   = '0;
            e_neg   = 1'b0;
            e_radix = i_cfg.number_base;
            e_any   = 1'b0;
            e_err   = 1'b0;
            e_pos   = '0;
        end else begin
            e_phase = r_phase;
            e_acc   = r_acc;
            e_neg   = r_neg;
            e_radix = r_radix;
            e_any   = r_any;
            e_err   = r_err;
            e_pos   = r_pos;
        end
    end

    assign pos_inc = (e_pos == {OFFSET_BITS{1'b1}}) ? e_pos : e_pos + 1'b1;

    assign dig       = digit_of(c);
    assign is_ws     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
    assign lead_zero = (c == CH_ZERO) && ((e_radix == RADIX_AUTO) || (e_radix == RADIX_HEX)
                                          || (e_radix == RADIX_BIN));
    assign pfx_x     = ((c == CH_LX) || (c == CH_UX))
                       && ((e_radix == RADIX_AUTO) || (e_radix == RADIX_HEX));
    assign pfx_b     = ((c == CH_LB) || (c == CH_UB))
                       && ((e_radix == RADIX_AUTO) || (e_radix == RADIX_BIN));
    assign first_radix = (e_radix == RADIX_AUTO) ? RADIX_DEC : e_radix;
    assign zero_radix  = (e_radix == RADIX_AUTO) ? RADIX_OCT : e_radix;

    // which characters go through the digit step, and with which radix
    always_comb begin
        s_step  = 1'b0;
        s_radix = e_radix;
        s_any   = e_any;
        case (e_phase)
            PH_SPACE: begin
                s_step  = !is_ws && !is_sign && !lead_zero;
                s_radix = first_radix;
            end
            PH_SIGNED: begin
                s_step  = !lead_zero;
                s_radix = first_radix;
            end
            PH_ZERO: begin
                s_step  = !pfx_x && !pfx_b;
                s_radix = zero_radix;
                s_any   = 1'b1;
            end
            PH_DIGITS: begin
                s_step  = 1'b1;
            end
            default: begin
                s_step  = 1'b0;
            end
        endcase
    end

    assign d_ok  = dig.ok && (s_radix != RADIX_AUTO) && (dig.val < s_radix);
    assign emit  = s_step && !d_ok;

    assign smax  = {1'b0, {(WORD_BITS-1){1'b1}}};
    assign smin  = {1'b1, {(WORD_BITS-1){1'b0}}};
    assign limit = i_cfg.signed_mode ? (e_neg ? smin : smax) : {WORD_BITS{1'b1}};
    assign prod  = PROD_BITS'(e_acc) * PROD_BITS'(s_radix) + PROD_BITS'(dig.val);
    assign ovf   = prod > PROD_BITS'(limit);

    // next state
    always_comb begin
        n_phase = e_phase;
        n_acc   = e_acc;
        n_neg   = e_neg;
        n_radix = e_radix;
        n_any   = e_any;
        n_err   = e_err;
        n_pos   = e_pos;
        case (e_phase)
            PH_SPACE: begin
                if (is_ws) begin
                    n_pos = pos_inc;
                end else if (is_sign) begin
                    n_neg   = (c == CH_MINUS);
                    n_phase = PH_SIGNED;
                    n_pos   = pos_inc;
                end else if (lead_zero) begin
                    n_phase = PH_ZERO;
                    n_pos   = pos_inc;
                end
            end
            PH_SIGNED: begin
                if (lead_zero) begin
                    n_phase = PH_ZERO;
                    n_pos   = pos_inc;
                end
            end
            PH_ZERO: begin
                if (pfx_x) begin
                    n_phase = PH_DIGITS;
                    n_radix = RADIX_HEX;
                    n_pos   = pos_inc;
                end else if (pfx_b) begin
                    n_phase = PH_DIGITS;
                    n_radix = RADIX_BIN;
                    n_pos   = pos_inc;
                end
            end
            default: begin
                n_phase = e_phase;
            end
        endcase
        if (s_step) begin
            n_radix = s_radix;
            n_any   = s_any;
            if (d_ok) begin
                n_phase = PH_DIGITS;
                n_any   = 1'b1;
                n_pos   = pos_inc;
                if (!e_err) begin
                    if (ovf) begin
                        n_err = 1'b1;
                    end else begin
                        n_acc = prod[WORD_BITS-1:0];
                    end
                end
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    // result
    always_comb begin
        if (e_err) begin
            word_val = i_cfg.signed_mode ? (e_neg ? smin : smax) : {WORD_BITS{1'b1}};
        end else begin
            word_val = e_neg ? (~e_acc + 1'b1) : e_acc;
        end
        val_wide = 64'(word_val);
        pos_wide = 32'(e_pos);
        n_value  = val_wide[VALUE_OUT_BITS-1:0];
        n_ovf    = e_err;
        n_found  = s_any;
        n_offset = s_any ? pos_wide[OFFSET_OUT_BITS-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_radix <= BASE_RESET;
            r_any   <= 1'b0;
            r_err   <= 1'b0;
            r_pos   <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_radix <= n_radix;
            r_any   <= n_any;
            r_err   <= n_err;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_value  <= n_value;
            r_ovf    <= n_ovf;
            r_found  <= n_found;
            r_offset <= n_offset;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.value_bits   = r_value;
    assign o_out.overflowed   = r_ovf;
    assign o_out.digits_found = r_found;
    assign o_out.end_offset   = r_offset;

endmodule

[rtl/string_to_integer_parser.sv]
// Channel  | Dir | Payload                                               | Handshake
// i_in     | in  | char_code, starts_string                              | valid/ready
// o_out    | out | value_bits, overflowed, digits_found, end_offset      | valid/ready
// APB      | in  | number_base @ 0x0, signed_mode @ 0x4                  | psel/penable
//
// One character per cycle, unless a stalled result blocks the core from taking one.
// The rate is set by the digit multiply-add and limit compare between the input
// register and the parse state / result register.
// Reset is synchronous; it clears both registers' valid bits and restarts the parse.
// A stalled result holds; one more character is taken into the input register meanwhile.
`timescale 1ns / 1ps

module string_to_integer_parser #(
    parameter int WORD_BITS   = 32,
    parameter int OFFSET_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    s2i_in_if.sink                            i_in,
    s2i_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [s2i_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [s2i_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [s2i_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import s2i_pkg::*;

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  take;

    s2i_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    s2i_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    s2i_core #(
        .WORD_BITS   (WORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .o_out        (o_out)
    );

endmodule

[rtl/s2i_checker.sv]
`timescale 1ns / 1ps

module s2i_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [s2i_pkg::VALUE_OUT_BITS-1:0]  i_value_bits,
    input logic                                i_overflowed,
    input logic                                i_digits_found,
    input logic [s2i_pkg::OFFSET_OUT_BITS-1:0] i_end_offset
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_no_digits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_digits_found |->
            i_value_bits == '0 && i_end_offset == '0 && !i_overflowed)
        else $error("empty parse with nonzero result fields");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while result side is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value_bits))
        else $error("stalled result transaction changed");

endmodule

bind string_to_integer_parser s2i_checker u_s2i_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_value_bits   (o_out.value_bits),
    .i_overflowed   (o_out.overflowed),
    .i_digits_found (o_out.digits_found),
    .i_end_offset   (o_out.end_offset)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import s2i_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          SWEEP_LEN      = 14;
    localparam int unsigned MAX_RADIX      = 36;

    typedef struct packed {
        logic [VALUE_OUT_BITS-1:0]  value;
        logic                       ovf;
        logic                       seen;
        logic [OFFSET_OUT_BITS-1:0] offset;
    } t_number;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    s2i_in_if  char_ch ();
    s2i_out_if num_ch ();

    string_to_integer_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_ch),
        .o_out   (num_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // register shadow
    logic [BASE_BITS-1:0] cfg_base   = BASE_RESET;
    logic                 cfg_signed = SIGNED_RESET;

    // parse state mirror
    t_phase               num_phase;
    logic [63:0]          num_mag;
    logic                 num_neg;
    logic [BASE_BITS-1:0] num_radix;
    logic                 num_seen;
    logic                 num_sat;
    logic [11:0]          num_pos;

    t_item   pending_chars[$];
    t_number expected_numbers[$];

    logic        mark_next;
    bit          no_idle;
    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned idle_cycles;
    int unsigned chars_queued;
    int unsigned chars_accepted;
    int unsigned strings_queued;
    int unsigned numbers_checked;
    int unsigned numbers_saturated;
    int unsigned settings_used;
    int unsigned mismatches;

    function automatic int char_weight(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
        end
        if (c >= CH_UA && c <= CH_UZ) begin
            return int'(c - CH_UA) + 10;
        end
        if (c >= CH_LA && c <= CH_LZ) begin
            return int'(c - CH_LA) + 10;
        end
        return -1;
    endfunction

    function automatic void restart_number();
        num_phase = PH_SPACE;
        num_mag   = '0;
        num_neg   = 1'b0;
        num_radix = cfg_base;
        num_seen  = 1'b0;
        num_sat   = 1'b0;
        num_pos   = '0;
    endfunction

    function automatic void bump_pos();
        if (num_pos != 12'hFFF) begin
            num_pos = num_pos + 1'b1;
        end
    endfunction

    function automatic void finish_number();
        t_number n;
        if (num_sat) begin
            n.value = cfg_signed ? (num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : 32'hFFFF_FFFF;
        end else if (num_neg) begin
            n.value = 32'(64'd0 - num_mag);
        end else begin
            n.value = num_mag[31:0];
        end
        n.ovf    = num_sat;
        n.seen   = num_seen;
        n.offset = num_seen ? num_pos : '0;
        if (num_sat) begin
            numbers_saturated++;
        end
        expected_numbers.push_back(n);
        num_phase = PH_DONE;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        int          w;
        logic [63:0] lim;
        w = char_weight(c);
        if (w < 0 || num_radix == RADIX_AUTO || w >= int'(num_radix)) begin
            finish_number();
            return;
        end
        num_seen = 1'b1;
        if (!num_sat) begin
            lim = cfg_signed ? (64'h7FFF_FFFF + num_neg) : 64'hFFFF_FFFF;
            if (num_mag > (lim - 64'(w)) / 64'(num_radix)) begin
                num_sat = 1'b1;
            end else begin
                num_mag = num_mag * 64'(num_radix) + 64'(w);
            end
        end
        bump_pos();
    endfunction

    function automatic void lead_char(input logic [7:0] c);
        if (c == CH_ZERO &&
            (num_radix == RADIX_AUTO || num_radix == RADIX_HEX || num_radix == RADIX_BIN)) begin
            num_phase = PH_ZERO;
            bump_pos();
            return;
        end
        if (num_radix == RADIX_AUTO) begin
            num_radix = RADIX_DEC;
        end
        num_phase = PH_DIGITS;
        take_digit(c);
    endfunction

    function automatic void after_zero(input logic [7:0] c);
        num_phase = PH_DIGITS;
        if ((c == CH_LX || c == CH_UX) && (num_radix == RADIX_AUTO || num_radix == RADIX_HEX)) begin
            num_radix = RADIX_HEX;
            bump_pos();
        end else if ((c == CH_LB || c == CH_UB) &&
                     (num_radix == RADIX_AUTO || num_radix == RADIX_BIN)) begin
            num_radix = RADIX_BIN;
            bump_pos();
        end else begin
            if (num_radix == RADIX_AUTO) begin
                num_radix = RADIX_OCT;
            end
            num_seen = 1'b1;
            take_digit(c);
        end
    endfunction

    function automatic void parse_char(input t_item it);
        logic [7:0] c;
        c = it.char_code;
        if (it.starts_string) begin
            restart_number();
        end
        case (num_phase)
            PH_SPACE: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    bump_pos();
                end else if (c == CH_MINUS || c == CH_PLUS) begin
                    num_neg   = (c == CH_MINUS);
                    num_phase = PH_SIGNED;
                    bump_pos();
                end else begin
                    lead_char(c);
                end
            end
            PH_SIGNED: lead_char(c);
            PH_ZERO:   after_zero(c);
            PH_DIGITS: take_digit(c);
            default:   ;
        endcase
    endfunction

    function automatic void queue_char(input logic [7:0] c);
        t_item it;
        it.char_code     = c;
        it.starts_string = mark_next;
        if (mark_next) begin
            strings_queued++;
        end
        mark_next = 1'b0;
        pending_chars.push_back(it);
        chars_queued++;
    endfunction

    function automatic void queue_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(s[i]);
        end
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned v);
        if (v < 10) begin
            return CH_ZERO + 8'(v);
        end
        return ($urandom_range(0, 1) != 0) ? CH_UA + 8'(v - 10) : CH_LA + 8'(v - 10);
    endfunction

    function automatic void queue_random_number();
        int unsigned          r;
        int unsigned          n;
        int unsigned          radix_eff;
        int unsigned          digs[64];
        logic [63:0]          lim;
        bit                   minus;
        mark_next = ($urandom_range(0, 19) != 0);
        r = $urandom_range(0, 99);
        if (r < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) queue_char(8'($urandom_range(0, 255)));
            return;
        end
        if (r < 20 && cfg_base >= RADIX_BIN && cfg_base <= MAX_RADIX) begin
            // values one below, at and one above the range limit
            minus = ($urandom_range(0, 1) != 0);
            if (minus) begin
                queue_char(CH_MINUS);
            end
            lim = cfg_signed ? (64'h7FFF_FFFF + minus) : 64'hFFFF_FFFF;
            lim = lim - 1 + $urandom_range(0, 2);
            n = 0;
            do begin
                digs[n] = int'(lim % cfg_base);
                lim     = lim / cfg_base;
                n++;
            end while (lim != 0);
            while (n > 0) begin
                n--;
                queue_char(digit_char(digs[n]));
            end
            queue_char(8'h00);
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 5);
            queue_char((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
        end
        r = $urandom_range(0, 3);
        if (r == 0) begin
            queue_char(CH_MINUS);
        end else if (r == 1) begin
            queue_char(CH_PLUS);
        end
        radix_eff = (cfg_base == RADIX_AUTO) ? RADIX_DEC : cfg_base;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            queue_char(CH_ZERO);
            queue_char(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
            if (cfg_base == RADIX_AUTO || cfg_base == RADIX_HEX) begin
                radix_eff = RADIX_HEX;
            end
        end else if (r == 1) begin
            queue_char(CH_ZERO);
            queue_char(($urandom_range(0, 1) != 0) ? CH_LB : CH_UB);
            if (cfg_base == RADIX_AUTO || cfg_base == RADIX_BIN) begin
                radix_eff = RADIX_BIN;
            end
        end else if (r == 2) begin
            queue_char(CH_ZERO);
            if (cfg_base == RADIX_AUTO) begin
                radix_eff = RADIX_OCT;
            end
        end
        if (radix_eff > MAX_RADIX) begin
            radix_eff = MAX_RADIX;
        end
        r = $urandom_range(0, 9);
        n = (r == 0) ? 0 : (r < 3) ? $urandom_range(12, 40) : $urandom_range(1, 10);
        repeat (n) queue_char(digit_char($urandom_range(0, radix_eff - 1)));
        case ($urandom_range(0, 3))
            0: queue_char(8'h00);
            1: queue_char(8'($urandom_range(0, 255)));
            2: queue_char(8'($urandom_range(8'h21, 8'h2F)));
            default: begin
                if (radix_eff < MAX_RADIX) begin
                    queue_char(digit_char($urandom_range(radix_eff, MAX_RADIX - 1)));
                end else begin
                    queue_char(8'h00);
                end
            end
        endcase
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) queue_char(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h (number %0d)",
                 $time, what, got, want, numbers_checked);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NUMBER_BASE) begin
            cfg_base = data[BASE_BITS-1:0];
        end else begin
            cfg_signed = data[0];
        end
    endtask

    task automatic settle();
        while (chars_accepted != chars_queued || expected_numbers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // character driver
    always @(posedge i_clk) begin : drive_chars
        t_item nxt;
        if (!i_rst_n) begin
            char_ch.valid         <= 1'b0;
            char_ch.char_code     <= '0;
            char_ch.starts_string <= 1'b0;
            send_gap              <= 0;
        end else if (!char_ch.valid || char_ch.ready) begin
            if (send_gap != 0) begin
                send_gap      <= send_gap - 1;
                char_ch.valid <= 1'b0;
            end else if (pending_chars.size() != 0 && !no_idle && $urandom_range(0, 99) < 20) begin
                send_gap      <= gap_len() - 1;
                char_ch.valid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
                nxt = pending_chars.pop_front();
                char_ch.valid         <= 1'b1;
                char_ch.char_code     <= nxt.char_code;
                char_ch.starts_string <= nxt.starts_string;
            end else begin
                char_ch.valid <= 1'b0;
            end
        end
    end

    // result sink, checker and watchdog
    always @(posedge i_clk) begin : watch_channels
        t_number got;
        t_number want;
        t_item   seen_char;
        if (!i_rst_n) begin
            num_ch.ready <= 1'b0;
            recv_stall   <= 0;
            idle_cycles  <= 0;
            restart_number();
        end else begin
            if (recv_stall != 0) begin
                recv_stall   <= recv_stall - 1;
                num_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 20) begin
                recv_stall   <= gap_len() - 1;
                num_ch.ready <= 1'b0;
            end else begin
                num_ch.ready <= 1'b1;
            end

            if (num_ch.valid && num_ch.ready) begin
                got = '{num_ch.value_bits, num_ch.overflowed, num_ch.digits_found,
                        num_ch.end_offset};
                if (expected_numbers.size() == 0) begin
                    report_mismatch("unexpected transaction", got.value, '0);
                end else begin
                    want = expected_numbers.pop_front();
                    if (got.value != want.value) begin
                        report_mismatch("value_bits", got.value, want.value);
                    end
                    if (got.ovf != want.ovf) begin
                        report_mismatch("overflowed", 32'(got.ovf), 32'(want.ovf));
                    end
                    if (got.seen != want.seen) begin
                        report_mismatch("digits_found", 32'(got.seen), 32'(want.seen));
                    end
                    if (got.offset != want.offset) begin
                        report_mismatch("end_offset", 32'(got.offset), 32'(want.offset));
                    end
                end
                numbers_checked++;
            end

            if (char_ch.valid && char_ch.ready) begin
                seen_char.char_code     = char_ch.char_code;
                seen_char.starts_string = char_ch.starts_string;
                parse_char(seen_char);
                chars_accepted++;
            end

            if ((num_ch.valid && num_ch.ready) || (char_ch.valid && char_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, expected_numbers.size());
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : run_test
        int unsigned sweep_base[SWEEP_LEN] = '{0, 16, 2, 36, 0, 8, 1, 63, 37, 0, 2, 16, 10, 0};
        bit          sweep_signed[SWEEP_LEN] = '{1, 0, 1, 0, 0, 1, 1, 0, 1, 1, 0, 1, 0, 0};
        int unsigned target;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        no_idle               = 1'b0;
        mark_next             = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first string without a start mark, then sign, zero, saturation, junk byte
        queue_string(" -12");
        queue_char(8'h00);
        mark_next = 1'b1;
        queue_string("+0z");
        mark_next = 1'b1;
        queue_string("99999999999,");
        mark_next = 1'b1;
        queue_char(8'hFF);
        settle();

        for (int p = 0; p < SWEEP_LEN; p++) begin
            write_reg(REG_NUMBER_BASE, ($urandom() & ~32'h3F) | sweep_base[p]);
            write_reg(REG_SIGNED_MODE, ($urandom() & ~32'h1) | sweep_signed[p]);
            settings_used++;
            no_idle = ($urandom_range(0, 3) == 0);
            target  = chars_queued + 95;
            while (chars_queued < target) begin
                queue_random_number();
            end
            settle();
        end

        $display("Covered %0d characters in %0d strings over %0d register settings.",
                 chars_accepted, strings_queued, settings_used + 1);
        $display("Checked %0d numbers (%0d saturated); %0d mismatches.",
                 numbers_checked, numbers_saturated, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
